/* sv/ptbc_pkg.sv */
`default_nettype none
package ptbc_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int BURST_MAX = 64;
	localparam int SAMPLE_BITS = 16;

	localparam int BL_W = 7;
	localparam int TP_W = 16;
	localparam int PEAKS_W = 17;
	localparam logic [PEAKS_W-1:0] PEAKS_SAT = '1;
	localparam logic [BL_W-1:0] BL_RESET = 7'd64;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_BURST_LEN = 1'b0;
	localparam logic REG_THROWAWAY_PEAKS = 1'b1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_i;
		logic signed [SAMPLE_BITS-1:0] sample_q;
		logic peak;
	} sample_beat_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_i;
		logic signed [SAMPLE_BITS-1:0] out_q;
		logic last_of_burst;
	} burst_beat_t;

	typedef struct packed {
		logic step;
		logic pop;
		logic open_new;
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

/* sv/ptbc_ram.sv */
`default_nettype none
module ptbc_ram #(
	parameter int WIDTH = 2 * ptbc_pkg::SAMPLE_BITS,
	parameter int DEPTH = ptbc_pkg::BURST_MAX,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* sv/ptbc_cell.sv */
`default_nettype none
module ptbc_cell #(
	parameter int QUEUE_DEPTH = ptbc_pkg::QUEUE_DEPTH,
	parameter int BURST_MAX = ptbc_pkg::BURST_MAX,
	localparam int FILL_W = $clog2(BURST_MAX + 1),
	localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
	localparam int AW = (BURST_MAX > 1) ? $clog2(BURST_MAX) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ptbc_pkg::cell_ctl_t ctl,
	input  wire logic [FILL_W-1:0]   len,
	input  wire logic [SLOT_W-1:0]   new_slot,
	input  wire logic                prev_open,
	input  wire logic                nb_open,
	input  wire logic [FILL_W-1:0]   nb_fill,
	input  wire logic [SLOT_W-1:0]   nb_slot,
	output logic                     cur_open,
	output logic                     upd_open,
	output logic      [FILL_W-1:0]   upd_fill,
	output logic      [SLOT_W-1:0]   upd_slot,
	output logic                     wr_en,
	output logic      [AW-1:0]       wr_addr
);

	logic              open_q;
	logic [FILL_W-1:0] fill_q;
	logic [SLOT_W-1:0] slot_q;
	logic              cap;
	logic              new_here;

	// new burst lands in the first free cell behind the open ones
	assign new_here = ctl.open_new && !open_q && prev_open;
	assign cap = open_q && (fill_q < len);

	assign cur_open = open_q;
	assign upd_open = open_q || new_here;
	assign upd_fill = new_here ? FILL_W'(1) : (cap ? fill_q + FILL_W'(1) : fill_q);
	assign upd_slot = new_here ? new_slot : slot_q;
	assign wr_en = ctl.step && (cap || new_here);
	assign wr_addr = new_here ? '0 : fill_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			fill_q <= '0;
			slot_q <= '0;
		end else if (ctl.step) begin
			if (ctl.pop) begin
				open_q <= nb_open;
				fill_q <= nb_fill;
				slot_q <= nb_slot;
			end else begin
				open_q <= upd_open;
				fill_q <= upd_fill;
				slot_q <= upd_slot;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/peak_triggered_burst_capture_unit.sv */
`default_nettype none
// Throughput: one sample per cycle while no burst is due for output.
// A sample that completes the oldest burst starts its output: the first beat is read
// from the slot's RAM bank into the read stage and then registered at the output,
// then one beat per cycle while the output is not stalled; samples are held off while
// the reads are issued. Reset clears queue cells, counters and control registers; the
// burst store and the read-stage and output data registers are not cleared.
module peak_triggered_burst_capture_unit #(
	parameter int QUEUE_DEPTH = ptbc_pkg::QUEUE_DEPTH,
	parameter int BURST_MAX = ptbc_pkg::BURST_MAX
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         sample_valid,
	output logic                              sample_ready,
	input  wire ptbc_pkg::sample_beat_t       sample,
	output logic                              burst_valid,
	input  wire logic                         burst_ready,
	output ptbc_pkg::burst_beat_t             burst,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [ptbc_pkg::APB_AW-1:0]  paddr,
	input  wire logic [ptbc_pkg::APB_DW-1:0]  pwdata,
	output logic      [ptbc_pkg::APB_DW-1:0]  prdata,
	output logic                              pready
);

	localparam int FILL_W = $clog2(BURST_MAX + 1);
	localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int AW = (BURST_MAX > 1) ? $clog2(BURST_MAX) : 1;
	localparam int WORD_W = 2 * ptbc_pkg::SAMPLE_BITS;

	logic [ptbc_pkg::BL_W-1:0]    burst_len_q;
	logic [ptbc_pkg::TP_W-1:0]    throwaway_peaks_q;
	logic [ptbc_pkg::PEAKS_W-1:0] peaks_seen_q;
	logic [SLOT_W-1:0]            tail_q;
	ptbc_pkg::state_t             state_q, state_d;

	logic [ptbc_pkg::BL_W-1:0] len_full;
	logic [FILL_W-1:0]         len;
	logic                      step;
	logic                      emit;
	logic                      counting;
	ptbc_pkg::cell_ctl_t       ctl;

	logic              cur_open [QUEUE_DEPTH];
	logic              upd_open [QUEUE_DEPTH];
	logic [FILL_W-1:0] upd_fill [QUEUE_DEPTH];
	logic [SLOT_W-1:0] upd_slot [QUEUE_DEPTH];
	logic              cell_we  [QUEUE_DEPTH];
	logic [AW-1:0]     cell_wa  [QUEUE_DEPTH];

	logic              bank_we    [QUEUE_DEPTH];
	logic [AW-1:0]     bank_waddr [QUEUE_DEPTH];
	logic [WORD_W-1:0] bank_rdata [QUEUE_DEPTH];
	logic [WORD_W-1:0] wdata;

	logic [SLOT_W-1:0] em_slot_q;
	logic [FILL_W-1:0] em_len_q;
	logic [AW-1:0]     em_cnt_q;
	logic              em_last;
	logic              issue;

	logic              rd_v_s1;
	logic              rd_last_s1;
	logic [SLOT_W-1:0] rd_slot_s1;
	logic              out_v_q;
	ptbc_pkg::burst_beat_t out_q;
	logic              adv1, adv2;
	logic [WORD_W-1:0] rd_word;
	logic              cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_len_q <= ptbc_pkg::BL_RESET;
			throwaway_peaks_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				ptbc_pkg::REG_BURST_LEN: begin
					burst_len_q <= pwdata[ptbc_pkg::BL_W-1:0];
				end
				ptbc_pkg::REG_THROWAWAY_PEAKS: begin
					throwaway_peaks_q <= pwdata[ptbc_pkg::TP_W-1:0];
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			ptbc_pkg::REG_BURST_LEN: begin
				prdata = {{(ptbc_pkg::APB_DW - ptbc_pkg::BL_W){1'b0}}, burst_len_q};
			end
			ptbc_pkg::REG_THROWAWAY_PEAKS: begin
				prdata = {{(ptbc_pkg::APB_DW - ptbc_pkg::TP_W){1'b0}}, throwaway_peaks_q};
			end
		endcase
	end

	// effective burst length
	always_comb begin
		if (burst_len_q == '0) begin
			len_full = ptbc_pkg::BL_W'(1);
		end else if (burst_len_q > ptbc_pkg::BL_W'(BURST_MAX)) begin
			len_full = ptbc_pkg::BL_W'(BURST_MAX);
		end else begin
			len_full = burst_len_q;
		end
	end
	assign len = len_full[FILL_W-1:0];

	assign step = sample_valid && sample_ready;
	assign counting = (peaks_seen_q <= {1'b0, throwaway_peaks_q});
	assign emit = upd_open[0] && (upd_fill[0] >= len);

	assign ctl.step = step;
	assign ctl.pop = step && emit;
	assign ctl.open_new = step && sample.peak && !counting && !cur_open[QUEUE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peaks_seen_q <= '0;
			tail_q <= '0;
		end else begin
			if (step && sample.peak && counting && (peaks_seen_q != ptbc_pkg::PEAKS_SAT)) begin
				peaks_seen_q <= peaks_seen_q + ptbc_pkg::PEAKS_W'(1);
			end
			if (ctl.open_new) begin
				tail_q <= (tail_q == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + SLOT_W'(1);
			end
		end
	end

	// row of queue cells, cell 0 holds the oldest burst
	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		logic              prev_open;
		logic              nb_open;
		logic [FILL_W-1:0] nb_fill;
		logic [SLOT_W-1:0] nb_slot;

		if (k == 0) begin : g_head
			assign prev_open = 1'b1;
		end else begin : g_body
			assign prev_open = cur_open[k-1];
		end

		if (k == QUEUE_DEPTH - 1) begin : g_tail
			assign nb_open = 1'b0;
			assign nb_fill = '0;
			assign nb_slot = '0;
		end else begin : g_link
			assign nb_open = upd_open[k+1];
			assign nb_fill = upd_fill[k+1];
			assign nb_slot = upd_slot[k+1];
		end

		ptbc_cell #(
			.QUEUE_DEPTH(QUEUE_DEPTH),
			.BURST_MAX(BURST_MAX)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.len(len),
			.new_slot(tail_q),
			.prev_open(prev_open),
			.nb_open(nb_open),
			.nb_fill(nb_fill),
			.nb_slot(nb_slot),
			.cur_open(cur_open[k]),
			.upd_open(upd_open[k]),
			.upd_fill(upd_fill[k]),
			.upd_slot(upd_slot[k]),
			.wr_en(cell_we[k]),
			.wr_addr(cell_wa[k])
		);
	end

	// route cell writes to the bank of their slot
	assign wdata = {sample.sample_q, sample.sample_i};

	always_comb begin
		for (int b = 0; b < QUEUE_DEPTH; b++) begin
			bank_we[b] = 1'b0;
			bank_waddr[b] = '0;
			for (int k = 0; k < QUEUE_DEPTH; k++) begin
				if (cell_we[k] && (upd_slot[k] == SLOT_W'(b))) begin
					bank_we[b] = 1'b1;
					bank_waddr[b] = bank_waddr[b] | cell_wa[k];
				end
			end
		end
	end

	for (genvar b = 0; b < QUEUE_DEPTH; b++) begin : g_bank
		ptbc_ram #(
			.WIDTH(WORD_W),
			.DEPTH(BURST_MAX)
		) u_ram (
			.clk(clk),
			.we(bank_we[b]),
			.waddr(bank_waddr[b]),
			.wdata(wdata),
			.re(issue && (em_slot_q == SLOT_W'(b))),
			.raddr(em_cnt_q),
			.rdata(bank_rdata[b])
		);
	end

	// output sequencer
	assign adv2 = !out_v_q || burst_ready;
	assign adv1 = !rd_v_s1 || adv2;
	assign em_last = (FILL_W'(em_cnt_q) + FILL_W'(1)) == em_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptbc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		sample_ready = 1'b0;
		issue = 1'b0;
		unique case (state_q)
			ptbc_pkg::ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid && emit) begin
					state_d = ptbc_pkg::ST_EMIT;
				end
			end
			ptbc_pkg::ST_EMIT: begin
				issue = adv1;
				if (adv1 && em_last) begin
					state_d = ptbc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ptbc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_slot_q <= '0;
			em_len_q <= '0;
			em_cnt_q <= '0;
		end else if (ctl.pop) begin
			em_slot_q <= upd_slot[0];
			em_len_q <= len;
			em_cnt_q <= '0;
		end else if (issue) begin
			em_cnt_q <= em_cnt_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else if (issue) begin
			rd_v_s1 <= 1'b1;
		end else if (adv2) begin
			rd_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_last_s1 <= em_last;
			rd_slot_s1 <= em_slot_q;
		end
	end

	assign rd_word = bank_rdata[rd_slot_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv2) begin
			out_v_q <= rd_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && rd_v_s1) begin
			out_q.out_i <= rd_word[ptbc_pkg::SAMPLE_BITS-1:0];
			out_q.out_q <= rd_word[WORD_W-1:ptbc_pkg::SAMPLE_BITS];
			out_q.last_of_burst <= rd_last_s1;
		end
	end

	assign burst_valid = out_v_q;
	assign burst = out_q;

endmodule
`default_nettype wire
